>>> sv/usd_pkg.sv
// Shared types, codes and header layout constants for the ustar stream deframer.
package usd_pkg;

  // Default width of the parsed size value
  localparam int SIZE_WIDTH_DEF = 64;

  // Header block layout
  localparam int BLOCK_LAST = 511;
  localparam int NAME_LEN   = 100;
  localparam int SIZE_OFF   = 124;
  localparam int SIZE_LEN   = 12;
  localparam int TYPE_OFF   = 156;
  localparam int MAGIC_OFF  = 257;
  localparam int MAGIC_LEN  = 5;

  // Byte values
  localparam logic [7:0] ASCII_0     = 8'h30;
  localparam logic [7:0] ASCII_7     = 8'h37;
  localparam logic [7:0] ASCII_SPACE = 8'h20;

  // Request operation codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  // Result kinds
  localparam logic [2:0] KIND_NAME  = 3'd0;
  localparam logic [2:0] KIND_START = 3'd1;
  localparam logic [2:0] KIND_BODY  = 3'd2;
  localparam logic [2:0] KIND_END   = 3'd3;
  localparam logic [2:0] KIND_ERROR = 3'd4;

  // Error codes
  localparam logic [2:0] ERR_NOT_USTAR = 3'd0;
  localparam logic [2:0] ERR_BAD_TYPE  = 3'd1;
  localparam logic [2:0] ERR_BAD_OCTAL = 3'd2;
  localparam logic [2:0] ERR_OVERFLOW  = 3'd3;
  localparam logic [2:0] ERR_TRUNCATED = 3'd4;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_BODY,
    PH_PAD,
    PH_DONE,
    PH_HALT
  } phase_t;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } usd_in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  out_byte;
    logic [63:0] entry_size;
    logic        last_body;
    logic [2:0]  error_code;
  } usd_out_t;

  // Expected magic character at a given position of the magic field
  function automatic logic [7:0] magic_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0: c = 8'h75;
      3'd1: c = 8'h73;
      3'd2: c = 8'h74;
      3'd3: c = 8'h61;
      3'd4: c = 8'h72;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

>>> sv/usd_core.sv
// Deframer state and per-byte header, body and padding decode.
module usd_core #(
  parameter int SIZE_WIDTH = usd_pkg::SIZE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  usd_pkg::usd_in_t   item,
  output logic               res_valid,
  output usd_pkg::usd_out_t  res
);
  import usd_pkg::*;

  phase_t                  phase_r, phase_nxt;
  logic [8:0]              offset_r;
  logic [SIZE_WIDTH-1:0]   size_r, size_nxt;
  logic [SIZE_WIDTH-1:0]   body_r;
  logic [8:0]              pad_r;
  logic                    all_zero_r, magic_ok_r, type_ok_r;
  logic                    oct_stop_r, oct_bad_r, bin_size_r, too_big_r, name_end_r;
  logic                    oct_stop_nxt, oct_bad_nxt, bin_size_nxt, too_big_nxt;
  logic                    magic_ok_nxt, type_ok_nxt, name_end_nxt;

  logic [7:0]              b;
  logic                    is_end;
  logic                    az_nxt;
  logic                    in_name, in_size, in_magic;
  logic [8:0]              magic_idx;
  logic                    name_emit;
  logic                    hdr_done, hdr_bad;
  logic [2:0]              hdr_code;
  logic [SIZE_WIDTH-1:0]   body_dec;
  logic                    body_last;
  logic [8:0]              pad_dec;
  logic [8:0]              new_pad;

  assign b      = item.data_byte;
  assign is_end = (item.op == OP_END);

  // Decode header field positions
  assign in_name   = (offset_r < 9'(NAME_LEN));
  assign in_size   = (offset_r >= 9'(SIZE_OFF)) && (offset_r < 9'(SIZE_OFF + SIZE_LEN));
  assign in_magic  = (offset_r >= 9'(MAGIC_OFF)) && (offset_r < 9'(MAGIC_OFF + MAGIC_LEN));
  assign magic_idx = offset_r - 9'(MAGIC_OFF);
  assign hdr_done  = (offset_r == 9'(BLOCK_LAST));
  assign az_nxt    = all_zero_r && (b == 8'h00);

  // Accumulate the size field, octal or base-256
  always_comb begin
    size_nxt     = size_r;
    bin_size_nxt = bin_size_r;
    oct_stop_nxt = oct_stop_r;
    oct_bad_nxt  = oct_bad_r;
    too_big_nxt  = too_big_r;
    if (in_size) begin
      if ((offset_r == 9'(SIZE_OFF)) && b[7]) begin
        bin_size_nxt = 1'b1;
        size_nxt     = SIZE_WIDTH'(b[6:0]);
      end else if (bin_size_r) begin
        if (size_r[SIZE_WIDTH-1 -: 8] != 8'h00) too_big_nxt = 1'b1;
        size_nxt = {size_r[SIZE_WIDTH-9:0], b};
      end else if (!oct_stop_r) begin
        if ((b == 8'h00) || (b == ASCII_SPACE)) begin
          oct_stop_nxt = 1'b1;
        end else if ((b < ASCII_0) || (b > ASCII_7)) begin
          oct_bad_nxt  = 1'b1;
          oct_stop_nxt = 1'b1;
        end else begin
          if (size_r[SIZE_WIDTH-1 -: 3] != 3'd0) too_big_nxt = 1'b1;
          size_nxt = {size_r[SIZE_WIDTH-4:0], b[2:0]};
        end
      end
    end
  end

  // Track magic, type flag and end of name
  assign magic_ok_nxt = magic_ok_r && !(in_magic && (b != magic_char(magic_idx[2:0])));
  assign type_ok_nxt  = (offset_r == 9'(TYPE_OFF)) ? ((b == ASCII_0) || (b == 8'h00))
                                                   : type_ok_r;
  assign name_end_nxt = name_end_r || (in_name && (b == 8'h00));
  assign name_emit    = in_name && (b != 8'h00) && !name_end_r;

  // Rank header errors: not ustar, bad type, bad octal, overflow
  always_comb begin
    hdr_bad  = !magic_ok_nxt || !type_ok_nxt || oct_bad_nxt || too_big_nxt;
    hdr_code = !magic_ok_nxt ? ERR_NOT_USTAR :
               !type_ok_nxt  ? ERR_BAD_TYPE  :
               oct_bad_nxt   ? ERR_BAD_OCTAL : ERR_OVERFLOW;
  end

  // Count down body and padding
  assign body_dec  = body_r - SIZE_WIDTH'(body_r != '0);
  assign body_last = (body_dec == '0);
  assign pad_dec   = pad_r - 9'(pad_r != 9'd0);
  assign new_pad   = 9'd0 - size_nxt[8:0];

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (step) begin
      case (phase_r)
        PH_HEADER: begin
          if (is_end)              phase_nxt = PH_HALT;
          else if (hdr_done) begin
            if (az_nxt)            phase_nxt = PH_DONE;
            else if (hdr_bad)      phase_nxt = PH_HALT;
            else if (size_nxt == '0) phase_nxt = PH_HEADER;
            else                   phase_nxt = PH_BODY;
          end
        end
        PH_BODY: begin
          if (is_end)              phase_nxt = PH_HALT;
          else if (body_last)      phase_nxt = (pad_r != 9'd0) ? PH_PAD : PH_HEADER;
        end
        PH_PAD: begin
          if (is_end)              phase_nxt = PH_HALT;
          else if (pad_dec == 9'd0) phase_nxt = PH_HEADER;
        end
        default: phase_nxt = phase_r;
      endcase
    end
  end

  // Result for this byte
  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    if (step) begin
      case (phase_r)
        PH_HEADER: begin
          if (is_end) begin
            res_valid      = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_TRUNCATED;
          end else if (hdr_done) begin
            res_valid = 1'b1;
            if (az_nxt) begin
              res.kind = KIND_END;
            end else if (hdr_bad) begin
              res.kind       = KIND_ERROR;
              res.error_code = hdr_code;
            end else begin
              res.kind       = KIND_START;
              res.entry_size = 64'(size_nxt);
            end
          end else if (name_emit) begin
            res_valid    = 1'b1;
            res.kind     = KIND_NAME;
            res.out_byte = b;
          end
        end
        PH_BODY: begin
          res_valid = 1'b1;
          if (is_end) begin
            res.kind       = KIND_ERROR;
            res.error_code = ERR_TRUNCATED;
          end else begin
            res.kind      = KIND_BODY;
            res.out_byte  = b;
            res.last_body = body_last;
          end
        end
        PH_PAD: begin
          if (is_end) begin
            res_valid      = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_TRUNCATED;
          end
        end
        default: res_valid = 1'b0;
      endcase
    end
  end

  // Update state on each processed request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      offset_r   <= 9'd0;
      size_r     <= '0;
      body_r     <= '0;
      pad_r      <= 9'd0;
      all_zero_r <= 1'b1;
      magic_ok_r <= 1'b1;
      type_ok_r  <= 1'b1;
      oct_stop_r <= 1'b0;
      oct_bad_r  <= 1'b0;
      bin_size_r <= 1'b0;
      too_big_r  <= 1'b0;
      name_end_r <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      case (phase_r)
        PH_HEADER: begin
          if (!is_end) begin
            if (hdr_done) begin
              // Start afresh for the next header block
              offset_r   <= 9'd0;
              size_r     <= '0;
              all_zero_r <= 1'b1;
              magic_ok_r <= 1'b1;
              type_ok_r  <= 1'b1;
              oct_stop_r <= 1'b0;
              oct_bad_r  <= 1'b0;
              bin_size_r <= 1'b0;
              too_big_r  <= 1'b0;
              name_end_r <= 1'b0;
              body_r     <= size_nxt;
              pad_r      <= new_pad;
            end else begin
              offset_r   <= offset_r + 9'd1;
              size_r     <= size_nxt;
              all_zero_r <= az_nxt;
              magic_ok_r <= magic_ok_nxt;
              type_ok_r  <= type_ok_nxt;
              oct_stop_r <= oct_stop_nxt;
              oct_bad_r  <= oct_bad_nxt;
              bin_size_r <= bin_size_nxt;
              too_big_r  <= too_big_nxt;
              name_end_r <= name_end_nxt;
            end
          end
        end
        PH_BODY: begin
          if (!is_end) body_r <= body_dec;
        end
        PH_PAD: begin
          if (!is_end) pad_r <= pad_dec;
        end
        default: pad_r <= pad_r;
      endcase
    end
  end

endmodule

>>> sv/ustar_stream_deframer.sv
// Top level of the ustar stream deframer: input register, decode core, result register.
//
//  channel | direction | payload    | handshake
//  --------+-----------+------------+----------------------
//  in_     | request   | usd_in_t   | in_valid / in_stall
//  out_    | result    | usd_out_t  | out_valid / out_stall
//
// One archive byte per clock unless a held result stalls the flow; a result passes through the
// input register and then the result register, set by the single decode pass in between.
// Reset is synchronous and active low; it returns the block to expecting a header.
// A pending result held by out_stall freezes the decode pass; in_stall rises only
// once the input register is also occupied.
module ustar_stream_deframer #(
  parameter int SIZE_WIDTH = usd_pkg::SIZE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  usd_pkg::usd_in_t   in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output usd_pkg::usd_out_t  out_item
);
  import usd_pkg::*;

  logic      s1_valid_r, s1_valid_nxt;
  usd_in_t   s1_item_r;
  logic      out_valid_r, out_valid_nxt;
  usd_out_t  out_item_r;
  logic      adv, in_acc, step;
  logic      res_valid;
  usd_out_t  res;

  // Advance whenever the result register is free or being taken
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !adv;
  assign in_acc   = in_valid && !in_stall;
  assign step     = s1_valid_r && adv;

  assign s1_valid_nxt  = adv ? in_acc : (s1_valid_r || in_acc);
  assign out_valid_nxt = adv ? res_valid : out_valid_r;

  usd_core #(
    .SIZE_WIDTH(SIZE_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .item     (s1_item_r),
    .res_valid(res_valid),
    .res      (res)
  );

  // Hold control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture request and result payloads
  always_ff @(posedge clk) begin
    if (in_acc) s1_item_r <= in_item;
    if (adv && res_valid) out_item_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

>>> sv/usd_checker.sv
// Port-level assertions for the ustar stream deframer, bound to the top level.
module usd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input usd_pkg::usd_in_t   in_item,
  input logic               out_valid,
  input logic               out_stall,
  input usd_pkg::usd_out_t  out_item
);
  import usd_pkg::*;

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // Drop results after an error is delivered
  a_halt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && (out_item.kind == KIND_ERROR) |=> !out_valid ##1 !out_valid)
    else $error("result after error");

  // Clear results on reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Keep unused fields zero
  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.kind != KIND_ERROR) |->
      (out_item.error_code == 3'd0) &&
      ((out_item.kind == KIND_BODY) || (out_item.last_body == 1'b0)) &&
      ((out_item.kind == KIND_START) || (out_item.entry_size == 64'd0)))
    else $error("stray field in result");

endmodule

bind ustar_stream_deframer usd_checker u_chk (.*);
